// ----- rtl/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, register indexes and the Morse code table for the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int unsigned CharWidth    = 8;
   localparam int unsigned DurWidth     = 16;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned MaxElements  = 5;
   localparam int unsigned ElemCntWidth = $clog2(MaxElements);
   localparam int unsigned ElemLenWidth = $clog2(MaxElements + 1);

   localparam logic [DurWidth-1:0] DotTimeReset        = 16'd1;
   localparam logic [DurWidth-1:0] DashTimeReset       = 16'd3;
   localparam logic [DurWidth-1:0] ElementGapTimeReset = 16'd1;
   localparam logic [DurWidth-1:0] LetterGapTimeReset  = 16'd3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DOT_TIME         = 2'd0,
      CSR_DASH_TIME        = 2'd1,
      CSR_ELEMENT_GAP_TIME = 2'd2,
      CSR_LETTER_GAP_TIME  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ELEM_GAP,
      ST_UNKNOWN,
      ST_LETTER_GAP
   } state_type;

   typedef enum logic [1:0] {
      SEG_MARK,
      SEG_ELEM_GAP,
      SEG_LETTER_GAP
   } seg_sel_type;

   typedef struct packed {
      logic        load;
      logic        emit;
      seg_sel_type seg_sel;
      logic        last;
      logic        advance;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic known;
      logic elem_last;
   } status_type;

   // pattern is left aligned: first element in the top bit, 1 means dash
   typedef struct packed {
      logic                    known;
      logic [ElemLenWidth-1:0] len;
      logic [MaxElements-1:0]  pattern;
   } code_type;

   function automatic code_type morse_lookup(input logic [CharWidth-1:0] ch);
      code_type c;
      c = '{known: 1'b1, len: 3'd0, pattern: 5'b00000};
      case (ch)
         8'h41: begin c.len = 3'd2; c.pattern = 5'b01000; end // A
         8'h42: begin c.len = 3'd4; c.pattern = 5'b10000; end // B
         8'h43: begin c.len = 3'd4; c.pattern = 5'b10100; end // C
         8'h44: begin c.len = 3'd3; c.pattern = 5'b10000; end // D
         8'h45: begin c.len = 3'd1; c.pattern = 5'b00000; end // E
         8'h46: begin c.len = 3'd4; c.pattern = 5'b00100; end // F
         8'h47: begin c.len = 3'd3; c.pattern = 5'b11000; end // G
         8'h48: begin c.len = 3'd4; c.pattern = 5'b00000; end // H
         8'h49: begin c.len = 3'd2; c.pattern = 5'b00000; end // I
         8'h4A: begin c.len = 3'd4; c.pattern = 5'b01110; end // J
         8'h4B: begin c.len = 3'd3; c.pattern = 5'b10100; end // K
         8'h4C: begin c.len = 3'd4; c.pattern = 5'b01000; end // L
         8'h4D: begin c.len = 3'd2; c.pattern = 5'b11000; end // M
         8'h4E: begin c.len = 3'd2; c.pattern = 5'b10000; end // N
         8'h4F: begin c.len = 3'd3; c.pattern = 5'b11100; end // O
         8'h50: begin c.len = 3'd4; c.pattern = 5'b01100; end // P
         8'h51: begin c.len = 3'd4; c.pattern = 5'b11010; end // Q
         8'h52: begin c.len = 3'd3; c.pattern = 5'b01000; end // R
         8'h53: begin c.len = 3'd3; c.pattern = 5'b00000; end // S
         8'h54: begin c.len = 3'd1; c.pattern = 5'b10000; end // T
         8'h55: begin c.len = 3'd3; c.pattern = 5'b00100; end // U
         8'h56: begin c.len = 3'd4; c.pattern = 5'b00010; end // V
         8'h57: begin c.len = 3'd3; c.pattern = 5'b01100; end // W
         8'h58: begin c.len = 3'd4; c.pattern = 5'b10010; end // X
         8'h59: begin c.len = 3'd4; c.pattern = 5'b10110; end // Y
         8'h5A: begin c.len = 3'd4; c.pattern = 5'b11000; end // Z
         8'h30: begin c.len = 3'd5; c.pattern = 5'b11111; end // 0
         8'h31: begin c.len = 3'd5; c.pattern = 5'b01111; end // 1
         8'h32: begin c.len = 3'd5; c.pattern = 5'b00111; end // 2
         8'h33: begin c.len = 3'd5; c.pattern = 5'b00011; end // 3
         8'h34: begin c.len = 3'd5; c.pattern = 5'b00001; end // 4
         8'h35: begin c.len = 3'd5; c.pattern = 5'b00000; end // 5
         8'h36: begin c.len = 3'd5; c.pattern = 5'b10000; end // 6
         8'h37: begin c.len = 3'd5; c.pattern = 5'b11000; end // 7
         8'h38: begin c.len = 3'd5; c.pattern = 5'b11100; end // 8
         8'h39: begin c.len = 3'd5; c.pattern = 5'b11110; end // 9
         default: begin c.known = 1'b0; end
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/morse_character_keyer_unit.sv -----
// ----------------------------------------------------------------------------
// morse_character_keyer_unit
// International Morse encoder: one ASCII character in, key segments out.
// ----------------------------------------------------------------------------
//   channel   ports              direction   moves
//   request   req_*              in          one character word
//   response  rsp_*              out         one segment word (key, duration, last)
//   csr       csr_*              in          timing register write
//
// A known character of n elements is accepted, then sends a mark and an element
// gap word per element and a letter gap word; an unknown one sends two letter
// gap words. One segment per cycle goes into a single output register when free.
// Reset is synchronous; timing registers return to 1, 3, 1, 3.
// A stalled response holds the controller until the output register frees.
// ----------------------------------------------------------------------------
module morse_character_keyer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mck_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [mck_pkg::DurWidth-1:0]    csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mck_pkg::CharWidth-1:0]   req_character,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_key_on,
   output logic [mck_pkg::DurWidth-1:0]    rsp_duration,
   output logic                            rsp_last
);
   import mck_pkg::*;

   cmd_type    cmd;
   status_type status;

   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mck_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_character (req_character),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_on    (rsp_key_on),
      .rsp_duration  (rsp_duration),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- rtl/mck_dp.sv -----
// ----------------------------------------------------------------------------
// mck_dp
// Keyer datapath: timing registers, code latch, element counter, output word.
// ----------------------------------------------------------------------------
module mck_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mck_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [mck_pkg::DurWidth-1:0]    csr_data,
   input  logic [mck_pkg::CharWidth-1:0]   req_character,
   input  mck_pkg::cmd_type                cmd,
   output mck_pkg::status_type             status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_key_on,
   output logic [mck_pkg::DurWidth-1:0]    rsp_duration,
   output logic                            rsp_last
);
   import mck_pkg::*;

   logic [DurWidth-1:0]     dot_time_ff, dash_time_ff, elem_gap_ff, letter_gap_ff;
   code_type                code_ff, code_in;
   logic [ElemCntWidth-1:0] cnt_ff, cnt_in;
   logic                    valid_ff, valid_in;
   logic                    key_ff, key_in;
   logic [DurWidth-1:0]     dur_ff, dur_in;
   logic                    last_ff, last_in;
   logic                    is_dash;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_time_ff   <= DotTimeReset;
         dash_time_ff  <= DashTimeReset;
         elem_gap_ff   <= ElementGapTimeReset;
         letter_gap_ff <= LetterGapTimeReset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DOT_TIME:         dot_time_ff   <= csr_data;
            CSR_DASH_TIME:        dash_time_ff  <= csr_data;
            CSR_ELEMENT_GAP_TIME: elem_gap_ff   <= csr_data;
            CSR_LETTER_GAP_TIME:  letter_gap_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      code_in = cmd.load ? morse_lookup(req_character) : code_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.advance) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign is_dash = code_ff.pattern[ElemCntWidth'(MaxElements - 1) - cnt_ff];

   always_comb begin
      valid_in = cmd.emit | (valid_ff & ~rsp_ready);
      key_in   = key_ff;
      dur_in   = dur_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         last_in = cmd.last;
         case (cmd.seg_sel)
            SEG_MARK: begin
               key_in = 1'b1;
               dur_in = is_dash ? dash_time_ff : dot_time_ff;
            end
            SEG_ELEM_GAP: begin
               key_in = 1'b0;
               dur_in = elem_gap_ff;
            end
            default: begin
               key_in = 1'b0;
               dur_in = letter_gap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      cnt_ff  <= cnt_in;
      key_ff  <= key_in;
      dur_ff  <= dur_in;
      last_ff <= last_in;
   end

   assign status.out_free  = ~valid_ff | rsp_ready;
   assign status.known     = code_ff.known;
   assign status.elem_last = (ElemLenWidth'(cnt_ff) + 1'b1) == code_ff.len;

   assign rsp_valid    = valid_ff;
   assign rsp_key_on   = key_ff;
   assign rsp_duration = dur_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- rtl/mck_ctrl.sv -----
// ----------------------------------------------------------------------------
// mck_ctrl
// Keyer controller: steps through marks and gaps of one character.
// ----------------------------------------------------------------------------
module mck_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mck_pkg::status_type status,
   output mck_pkg::cmd_type    cmd
);
   import mck_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.emit    = 1'b0;
      cmd.seg_sel = SEG_LETTER_GAP;
      cmd.last    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (!status.known) begin
               state_in = ST_UNKNOWN;
            end else if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.seg_sel = SEG_MARK;
               state_in    = ST_ELEM_GAP;
            end
         end
         ST_ELEM_GAP: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.seg_sel = SEG_ELEM_GAP;
               if (status.elem_last) begin
                  state_in = ST_LETTER_GAP;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_MARK;
               end
            end
         end
         ST_UNKNOWN: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.seg_sel = SEG_LETTER_GAP;
               state_in    = ST_LETTER_GAP;
            end
         end
         ST_LETTER_GAP: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.seg_sel = SEG_LETTER_GAP;
               cmd.last    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
